// ===== hdl/rkq_pkg.sv =====
package rkq_pkg;

    localparam int MaxN = 1024;
    localparam int ValueBits = 16;

    // Request codes.
    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_BAD_RANGE = 2'd1;
    localparam logic [1:0] ST_BAD_RANK = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // latch the request and check it
        logic root_rd;     // read version roots
        logic step_rd;     // read the nodes of the current level
        logic step_wr;     // apply the current level
        logic root_wr;     // write the new version root
        logic done;        // publish the result
    } rkq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_walk;     // request needs a tree walk
        logic is_load;     // walk is a load
        logic last_level;  // current level is the leaf level
    } rkq_stat_t;

endpackage

// ===== hdl/rkq_ram.sv =====
module rkq_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/rkq_ctrl.sv =====
module rkq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  rkq_pkg::rkq_stat_t stat,
    output rkq_pkg::rkq_cmd_t  cmd
);
    import rkq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_READ  = 5'b00100,
        S_STEP  = 5'b01000,
        S_ROOT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence: check, then per level a node read and a node update, then a root write for a load.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.is_walk)
                begin
                    cmd.root_rd = 1'b1;
                    state_next = S_READ;
                end
                else
                begin
                    cmd.done = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.step_rd = 1'b1;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                cmd.step_wr = 1'b1;
                if (stat.last_level)
                begin
                    if (stat.is_load)
                    begin
                        state_next = S_ROOT;
                    end
                    else
                    begin
                        cmd.done = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_ROOT:
            begin
                cmd.root_wr = 1'b1;
                cmd.done = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== hdl/rkq_dp.sv =====
module rkq_dp #(
    parameter int MaxN = rkq_pkg::MaxN,
    parameter int ValueBits = rkq_pkg::ValueBits,
    localparam int PosW = $clog2(MaxN + 1),
    localparam int NodeDepth = 1 + MaxN * (ValueBits + 1),
    localparam int NodeW = $clog2(NodeDepth),
    localparam int VerW = $clog2(MaxN + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rkq_pkg::rkq_cmd_t     cmd,
    output rkq_pkg::rkq_stat_t    stat,
    input  logic [1:0]            req_type,
    input  logic [ValueBits-1:0]  value,
    input  logic [PosW-1:0]       left_pos,
    input  logic [PosW-1:0]       right_pos,
    input  logic [PosW-1:0]       rank_k,
    output logic [ValueBits-1:0]  kth_value,
    output logic [1:0]            status,
    output logic                  done
);
    import rkq_pkg::*;

    localparam int LvlW = $clog2(ValueBits + 1);
    localparam int NodeRec = 2 * NodeW + PosW;

    // Request registers.
    logic [1:0]           req_reg;
    logic [ValueBits-1:0] val_reg;
    logic [PosW-1:0]      lp_reg, rp_reg, k_reg, k_next;
    logic [PosW-1:0]      cnt_reg;
    logic [NodeW-1:0]     free_reg;
    logic                 walk_reg;
    logic [1:0]           st_reg;
    logic [LvlW-1:0]      lvl_reg;
    logic [ValueBits-1:0] acc_reg;
    // Walk pointers: u/v for queries, old/cur for loads.
    logic [NodeW-1:0]     u_ptr, v_ptr;
    logic [NodeW-1:0]     cur_reg;
    logic [NodeW-1:0]     root_new_reg;
    logic [ValueBits-1:0] out_val_reg;
    logic [1:0]           out_st_reg;
    logic                 done_reg;

    // Node memory: two read ports built as two copies with a shared write.
    // A node holds its two child links and the count under its left child.
    logic                 nwe;
    logic [NodeW-1:0]     nwaddr, nra, nrb;
    logic [NodeRec-1:0]   nwdata, nda, ndb;
    logic                 vwe;
    logic [VerW-1:0]      vwaddr, vra, vrb;
    logic [NodeW-1:0]     vwdata, vda, vdb;

    rkq_ram #(.Width(NodeRec), .Depth(NodeDepth)) u_node_a (
        .clk(clk), .we(nwe), .waddr(nwaddr), .wdata(nwdata), .raddr(nra), .rdata(nda));
    rkq_ram #(.Width(NodeRec), .Depth(NodeDepth)) u_node_b (
        .clk(clk), .we(nwe), .waddr(nwaddr), .wdata(nwdata), .raddr(nrb), .rdata(ndb));
    rkq_ram #(.Width(NodeW), .Depth(MaxN + 1)) u_root_a (
        .clk(clk), .we(vwe), .waddr(vwaddr), .wdata(vwdata), .raddr(vra), .rdata(vda));
    rkq_ram #(.Width(NodeW), .Depth(MaxN + 1)) u_root_b (
        .clk(clk), .we(vwe), .waddr(vwaddr), .wdata(vwdata), .raddr(vrb), .rdata(vdb));

    // Entry 0 of each store is the empty node; it is never written, so
    // reads of it are forced to zero.
    logic                 za_reg, zb_reg, vza_reg, vzb_reg;
    logic [NodeW-1:0]     a_left, a_right, b_left, b_right;
    logic [PosW-1:0]      a_ltally, b_ltally;
    logic [NodeW-1:0]     root_a, root_b;

    assign {a_left, a_right, a_ltally} = za_reg ? '0 : nda;
    assign {b_left, b_right, b_ltally} = zb_reg ? '0 : ndb;
    assign root_a = vza_reg ? '0 : vda;
    assign root_b = vzb_reg ? '0 : vdb;

    // Request checks.
    logic [1:0]      chk_st;
    logic            chk_walk;
    logic [PosW:0]   span;
    always_comb
    begin
        chk_st = ST_OK;
        chk_walk = 1'b0;
        span = {1'b0, rp_reg} - {1'b0, lp_reg} + 1'b1;
        case (req_reg)
            REQ_LOAD:
            begin
                if (cnt_reg >= PosW'(MaxN))
                begin
                    chk_st = ST_FULL;
                end
                else
                begin
                    chk_walk = 1'b1;
                end
            end
            REQ_QUERY:
            begin
                if (lp_reg == '0 || lp_reg > rp_reg || rp_reg > cnt_reg)
                begin
                    chk_st = ST_BAD_RANGE;
                end
                else if (k_reg == '0 || {1'b0, k_reg} > span)
                begin
                    chk_st = ST_BAD_RANK;
                end
                else
                begin
                    chk_walk = 1'b1;
                end
            end
            default:
            begin
                chk_st = ST_OK;
            end
        endcase
    end

    assign stat.is_walk = chk_walk;
    assign stat.is_load = (req_reg == REQ_LOAD);
    assign stat.last_level = (lvl_reg == '0);

    // Current level's branch decision. The value bit of a level is the one
    // below it; at the leaf level the shift runs past the top and gives zero.
    logic            bit_now;
    logic [LvlW-1:0] lvl_m1;
    logic [ValueBits-1:0] val_sh;
    logic [PosW-1:0] diff;
    logic            go_right;
    assign lvl_m1 = lvl_reg - 1'b1;
    assign val_sh = val_reg >> lvl_m1;
    assign bit_now = val_sh[0];
    // For a query the left-child counts of both versions are in the nodes read.
    assign diff = b_ltally - a_ltally;
    assign go_right = (req_reg == REQ_LOAD) ? bit_now : (k_reg > diff);
    assign k_next = k_reg - diff;

    // Memory addressing.
    always_comb
    begin
        nra = u_ptr;
        nrb = v_ptr;
        vra = VerW'(lp_reg - 1'b1);
        vrb = VerW'(rp_reg);
        vwe = 1'b0;
        vwaddr = VerW'(cnt_reg);
        vwdata = root_new_reg;
        nwe = 1'b0;
        nwaddr = cur_reg;
        nwdata = '0;
        if (cmd.root_rd && req_reg == REQ_LOAD)
        begin
            vra = VerW'(cnt_reg);
        end
        if (cmd.step_rd)
        begin
            // Read pointer nodes.
            nra = u_ptr;
            nrb = v_ptr;
        end
        if (cmd.root_wr)
        begin
            // The new version takes the slot after the last loaded one.
            vwe = 1'b1;
            vwaddr = VerW'(cnt_reg + 1'b1);
        end
        if (cmd.step_wr && req_reg == REQ_LOAD)
        begin
            // Copy the old node at this level; its child link on the path
            // points at the next free node, and a step to the left adds one
            // to the left count.
            nwe = 1'b1;
            nwaddr = cur_reg;
            if (lvl_reg == '0)
            begin
                nwdata = {a_left, a_right, a_ltally};
            end
            else if (bit_now)
            begin
                nwdata = {a_left, cur_reg + 1'b1, a_ltally};
            end
            else
            begin
                nwdata = {cur_reg + 1'b1, a_right, a_ltally + 1'b1};
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            free_reg <= NodeW'(1);
            done_reg <= 1'b0;
            req_reg <= REQ_CLEAR;
        end
        else
        begin
            done_reg <= cmd.done;
            if (cmd.capture)
            begin
                req_reg <= req_type;
                val_reg <= value;
                lp_reg <= left_pos;
                rp_reg <= right_pos;
            end
            if (cmd.step_wr && req_reg == REQ_LOAD && lvl_reg == '0)
            begin
                free_reg <= cur_reg + 1'b1;
            end
            if (cmd.done)
            begin
                out_st_reg <= walk_reg ? ST_OK : chk_st;
                out_val_reg <= (walk_reg && req_reg == REQ_QUERY) ? acc_reg : '0;
                if (!walk_reg && req_reg == REQ_CLEAR)
                begin
                    cnt_reg <= '0;
                    free_reg <= NodeW'(1);
                end
                if (cmd.root_wr)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    // Walk registers.
    always_ff @(posedge clk)
    begin
        za_reg <= (nra == '0);
        zb_reg <= (nrb == '0);
        vza_reg <= (vra == '0);
        vzb_reg <= (vrb == '0);
        if (cmd.capture)
        begin
            walk_reg <= 1'b0;
            k_reg <= rank_k;
        end
        if (cmd.root_rd)
        begin
            walk_reg <= 1'b1;
            lvl_reg <= LvlW'(ValueBits);
            acc_reg <= '0;
            cur_reg <= free_reg;
            root_new_reg <= free_reg;
        end
        if (cmd.step_wr)
        begin
            lvl_reg <= lvl_reg - 1'b1;
            if (req_reg == REQ_LOAD)
            begin
                cur_reg <= cur_reg + 1'b1;
            end
            else
            begin
                // Every level above the leaves decides one value bit.
                if (lvl_reg != '0)
                begin
                    acc_reg <= {acc_reg[ValueBits-2:0], go_right};
                    if (go_right)
                    begin
                        k_reg <= k_next;
                    end
                end
            end
        end
    end

    // Pointer tracking: the node read next is selected in the update cycle.
    logic [NodeW-1:0] pa_reg, pb_reg;
    logic             sel_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.root_rd)
        begin
            sel_reg <= 1'b1;
        end
        else if (cmd.step_rd)
        begin
            sel_reg <= 1'b0;
        end
        if (cmd.step_wr)
        begin
            pa_reg <= go_right ? a_right : a_left;
            pb_reg <= go_right ? b_right : b_left;
        end
    end

    // Pointers for the next node read: roots first, then chosen children.
    always_comb
    begin
        u_ptr = sel_reg ? root_a : pa_reg;
        v_ptr = sel_reg ? root_b : pb_reg;
    end

    assign kth_value = out_val_reg;
    assign status = out_st_reg;
    assign done = done_reg;

endmodule

// ===== hdl/range_kth_smallest_query_core.sv =====
// Channel   Signals                                       Direction
// request   start, busy, req_type, value, left_pos,       in (busy out)
//           right_pos, rank_k
// result    done, kth_value, status                       out
//
// A load or query walks one tree path of ValueBits+1 nodes, with a node read
// and a node update per node, since the node store has a registered read: a
// node is read in one state and used in the next. A load result also waits
// for the version root write. Error, clear and unused requests answer from
// the check state, without a walk.
// Reset clears the counts; the node store needs no clearing pass.
// The receiver cannot stall; a result is valid for the one cycle done is high.
module range_kth_smallest_query_core #(
    parameter int MaxN = rkq_pkg::MaxN,
    parameter int ValueBits = rkq_pkg::ValueBits,
    localparam int PosW = $clog2(MaxN + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           req_type,
    input  logic [ValueBits-1:0] value,
    input  logic [PosW-1:0]      left_pos,
    input  logic [PosW-1:0]      right_pos,
    input  logic [PosW-1:0]      rank_k,
    output logic                 done,
    output logic [ValueBits-1:0] kth_value,
    output logic [1:0]           status
);
    import rkq_pkg::*;

    rkq_cmd_t  cmd;
    rkq_stat_t stat;

    rkq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .stat(stat), .cmd(cmd));

    rkq_dp #(.MaxN(MaxN), .ValueBits(ValueBits)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .req_type(req_type), .value(value), .left_pos(left_pos),
        .right_pos(right_pos), .rank_k(rank_k),
        .kth_value(kth_value), .status(status), .done(done));

    // A result appears only while a request is in flight or just finished.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy)) else $error("result without request");

    // A request leaves busy high in the next cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("request not taken");

    // Error results carry a zero value.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (kth_value == '0))
        else $error("error result with value");

endmodule
